// ----- rtl/core/cmi_pkg.sv -----
// Shared types and fixed constants of the co-occurrence matrix and inertia block.
package cmi_pkg;

    // Fixed field widths of the ports
    localparam int PIXEL_BITS   = 8;
    localparam int CFG_BITS     = 4;
    localparam int BIN_OUT_BITS = 24;
    localparam int INERTIA_BITS = 48;

    // Request fields carried through the queue, sized for the widest level range
    localparam int REQ_ADDR_BITS = 2 * PIXEL_BITS;
    localparam int SQ_BITS       = 2 * PIXEL_BITS;

    // Queue geometry
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    // Request kinds on the input
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Operations handed from the front to the back
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // One queued operation for the back end
    typedef struct packed {
        logic [1:0]               op;
        logic [REQ_ADDR_BITS-1:0] addr;
        logic [SQ_BITS-1:0]       sq;
        logic                     oob;
    } cmi_req_t;

    // Status of the back end, watched by the checks at the top level
    typedef struct packed {
        logic sweep_active;
        logic stage2_valid;
        logic inertia_zero;
    } cmi_back_status_t;

endpackage

// ----- rtl/core/cmi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cmi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read at the written address returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/cmi_front.sv -----
// Front end: takes requests, keeps the row history and forms bin updates and reads.
module cmi_front #(
    parameter int LEVELS     = 256,
    parameter int OFFSET_MAX = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [cmi_pkg::CFG_BITS-1:0]       cfg_wr_data,
    input  logic                               accept,
    input  logic [1:0]                         kind,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]     pixel,
    input  logic                               row_start,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]     read_first,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]     read_second,
    output logic                               push,
    output cmi_pkg::cmi_req_t                  push_req
);

    localparam int LB        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int POS_BITS  = $clog2(OFFSET_MAX + 1);
    localparam int OFF_BITS  = POS_BITS;
    localparam int CW        = (OFF_BITS > cmi_pkg::CFG_BITS) ? OFF_BITS : cmi_pkg::CFG_BITS;
    localparam int HIDX_BITS = (OFFSET_MAX > 1) ? $clog2(OFFSET_MAX) : 1;
    localparam int EXT_BITS  = cmi_pkg::PIXEL_BITS + 1;

    logic [cmi_pkg::CFG_BITS-1:0] pair_offset_reg;
    logic [LB-1:0]                hist_reg [OFFSET_MAX];
    logic [POS_BITS-1:0]          pos_reg;
    logic [POS_BITS-1:0]          pos_next;

    logic [CW-1:0]        off_ext;
    logic [CW-1:0]        eff_off;
    logic [CW-1:0]        hidx_full;
    logic [HIDX_BITS-1:0] hidx;
    logic [POS_BITS-1:0]  pos_eff;
    logic                 pair;
    logic [LB-1:0]        level;
    logic [LB-1:0]        earlier;
    logic [LB-1:0]        diff;
    logic [2*LB-1:0]      sq;
    logic                 first_oob;
    logic                 second_oob;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_offset_reg <= cmi_pkg::CFG_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            pair_offset_reg <= cfg_wr_data;
        end
    end

    // Offset clamped into the range the history can serve
    always_comb
    begin
        off_ext = CW'(pair_offset_reg);
        if (off_ext == CW'(0))
        begin
            eff_off = CW'(1);
        end
        else if (off_ext > CW'(OFFSET_MAX))
        begin
            eff_off = CW'(OFFSET_MAX);
        end
        else
        begin
            eff_off = off_ext;
        end
        hidx_full = eff_off - CW'(1);
        hidx      = hidx_full[HIDX_BITS-1:0];
    end

    // Pixel level, pairing and squared difference
    always_comb
    begin
        if (EXT_BITS'(pixel) >= EXT_BITS'(LEVELS))
        begin
            level = LB'(LEVELS - 1);
        end
        else
        begin
            level = pixel[LB-1:0];
        end
        pos_eff = row_start ? POS_BITS'(0) : pos_reg;
        pair    = (CW'(pos_eff) >= eff_off);
        earlier = hist_reg[hidx];
        diff    = (earlier > level) ? (earlier - level) : (level - earlier);
        sq      = (2*LB)'(diff) * (2*LB)'(diff);
        if (pos_eff < POS_BITS'(OFFSET_MAX))
        begin
            pos_next = pos_eff + POS_BITS'(1);
        end
        else
        begin
            pos_next = pos_eff;
        end
        first_oob  = (EXT_BITS'(read_first) >= EXT_BITS'(LEVELS));
        second_oob = (EXT_BITS'(read_second) >= EXT_BITS'(LEVELS));
    end

    // Classify the accepted request into a queue entry
    always_comb
    begin
        push          = 1'b0;
        push_req.op   = cmi_pkg::OP_UPDATE;
        push_req.addr = cmi_pkg::REQ_ADDR_BITS'({earlier, level});
        push_req.sq   = cmi_pkg::SQ_BITS'(sq);
        push_req.oob  = 1'b0;
        unique case (kind)
            cmi_pkg::KIND_PIXEL:
            begin
                push = accept && pair;
            end
            cmi_pkg::KIND_READ:
            begin
                push          = accept;
                push_req.op   = cmi_pkg::OP_READ;
                push_req.addr = cmi_pkg::REQ_ADDR_BITS'({read_first[LB-1:0],
                                                         read_second[LB-1:0]});
                push_req.oob  = first_oob || second_oob;
            end
            cmi_pkg::KIND_CLEAR:
            begin
                push        = accept;
                push_req.op = cmi_pkg::OP_CLEAR;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Row history and position move on every accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < OFFSET_MAX; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (accept && (kind == cmi_pkg::KIND_PIXEL))
        begin
            pos_reg     <= pos_next;
            hist_reg[0] <= level;
            for (int i = 1; i < OFFSET_MAX; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

endmodule

// ----- rtl/core/cmi_queue.sv -----
// Short FIFO of operations between the front and back ends.
module cmi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cmi_pkg::cmi_req_t push_req,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output cmi_pkg::cmi_req_t head
);

    cmi_pkg::cmi_req_t                     store_reg [cmi_pkg::QUEUE_DEPTH];
    logic [cmi_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_reg;
    logic [cmi_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_reg;
    logic [cmi_pkg::QUEUE_CNT_BITS-1:0]    count_reg;
    logic [cmi_pkg::QUEUE_CNT_BITS-1:0]    count_next;

    assign full  = (count_reg == cmi_pkg::QUEUE_CNT_BITS'(cmi_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    // Occupancy follows the push and pop strobes
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + cmi_pkg::QUEUE_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - cmi_pkg::QUEUE_CNT_BITS'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + cmi_pkg::QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cmi_pkg::QUEUE_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ----- rtl/core/cmi_back.sv -----
// Back end: bin read-modify-write with forwarding, inertia sum, reads and clearing sweep.
module cmi_back #(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 empty,
    input  cmi_pkg::cmi_req_t                    head,
    output logic                                 pop,
    output logic                                 done,
    output logic [cmi_pkg::BIN_OUT_BITS-1:0]     bin_count,
    output logic [cmi_pkg::INERTIA_BITS-1:0]     inertia,
    output cmi_pkg::cmi_back_status_t            status
);

    localparam int LB         = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ADDR_BITS  = 2 * LB;
    localparam int DEPTH      = 1 << ADDR_BITS;
    localparam int IB         = cmi_pkg::INERTIA_BITS;

    logic                       s2_valid_reg;
    cmi_pkg::cmi_req_t          s2_req_reg;
    logic                       sweep_reg;
    logic [ADDR_BITS-1:0]       sweep_addr_reg;
    logic                       wr_valid_reg;
    logic [ADDR_BITS-1:0]       wr_addr_reg;
    logic [COUNT_BITS-1:0]      wr_data_reg;
    logic [IB-1:0]              inertia_sum_reg;
    logic [IB-1:0]              inertia_sum_next;
    logic                       done_reg;
    logic [cmi_pkg::BIN_OUT_BITS-1:0] bin_count_reg;
    logic [IB-1:0]              inertia_out_reg;

    logic                       we;
    logic [ADDR_BITS-1:0]       waddr;
    logic [COUNT_BITS-1:0]      wdata;
    logic [COUNT_BITS-1:0]      rdata;
    logic [ADDR_BITS-1:0]       s2_addr;
    logic [COUNT_BITS-1:0]      cur;
    logic [31:0]                cur_wide;
    logic [IB:0]                inertia_add;

    // Issue the next operation unless a clear is in progress or about to start
    assign pop = !empty && !sweep_reg &&
                 !(s2_valid_reg && (s2_req_reg.op == cmi_pkg::OP_CLEAR));

    cmi_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_bins (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (head.addr[ADDR_BITS-1:0]),
        .rdata (rdata)
    );

    // Current bin value, forwarding the write of the previous cycle
    always_comb
    begin
        s2_addr = s2_req_reg.addr[ADDR_BITS-1:0];
        if (wr_valid_reg && (wr_addr_reg == s2_addr))
        begin
            cur = wr_data_reg;
        end
        else
        begin
            cur = rdata;
        end
        cur_wide = 32'(cur);
    end

    // Write port: the clearing sweep, or a bin increment that is not saturated
    always_comb
    begin
        we    = 1'b0;
        waddr = s2_addr;
        wdata = cur + COUNT_BITS'(1);
        if (sweep_reg)
        begin
            we    = 1'b1;
            waddr = sweep_addr_reg;
            wdata = '0;
        end
        else if (s2_valid_reg && (s2_req_reg.op == cmi_pkg::OP_UPDATE) && (cur != '1))
        begin
            we = 1'b1;
        end
    end

    // Saturating inertia sum
    always_comb
    begin
        inertia_add      = {1'b0, inertia_sum_reg} + (IB+1)'(s2_req_reg.sq);
        inertia_sum_next = inertia_sum_reg;
        if (s2_valid_reg)
        begin
            case (s2_req_reg.op)
                cmi_pkg::OP_UPDATE:
                begin
                    inertia_sum_next = inertia_add[IB] ? '1 : inertia_add[IB-1:0];
                end
                cmi_pkg::OP_CLEAR:
                begin
                    inertia_sum_next = '0;
                end
                default:
                begin
                    inertia_sum_next = inertia_sum_reg;
                end
            endcase
        end
    end

    // Pipeline control, sweep and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg    <= 1'b0;
            sweep_reg       <= 1'b1;
            sweep_addr_reg  <= '0;
            wr_valid_reg    <= 1'b0;
            inertia_sum_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            s2_valid_reg    <= pop;
            wr_valid_reg    <= we;
            inertia_sum_reg <= inertia_sum_next;
            done_reg        <= s2_valid_reg && (s2_req_reg.op == cmi_pkg::OP_READ);
            if (sweep_reg)
            begin
                sweep_addr_reg <= sweep_addr_reg + ADDR_BITS'(1);
                if (sweep_addr_reg == '1)
                begin
                    sweep_reg <= 1'b0;
                end
            end
            else if (s2_valid_reg && (s2_req_reg.op == cmi_pkg::OP_CLEAR))
            begin
                sweep_reg      <= 1'b1;
                sweep_addr_reg <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s2_req_reg <= head;
        end
        wr_addr_reg <= waddr;
        wr_data_reg <= wdata;
        if (s2_valid_reg && (s2_req_reg.op == cmi_pkg::OP_READ))
        begin
            bin_count_reg   <= s2_req_reg.oob ? '0 : cur_wide[cmi_pkg::BIN_OUT_BITS-1:0];
            inertia_out_reg <= inertia_sum_reg;
        end
    end

    assign done      = done_reg;
    assign bin_count = bin_count_reg;
    assign inertia   = inertia_out_reg;

    assign status.sweep_active = sweep_reg;
    assign status.stage2_valid = s2_valid_reg;
    assign status.inertia_zero = (inertia_sum_reg == '0);

endmodule

// ----- rtl/core/cooccurrence_matrix_inertia.sv -----
// Top level of the horizontal-offset co-occurrence matrix with inertia sum.
//
//  Channel   Handshake            Payload
//  -------   ------------------   -----------------------------------------------
//  request   start, busy          kind, pixel, row_start, read_first, read_second
//  result    done (one cycle)     bin_count, inertia
//  config    cfg_wr_en            cfg_wr_data (pair offset)
//
// A request is taken on a rising edge with start high and busy low; the front end
// takes one per cycle and, outside a clearing sweep, the back end retires one per cycle
// through its bin read-modify-write, so the sustained rate there is one request per clock.
// A read passes the queue and the second-stage register before its result is registered.
// A clear request, and reset itself, sweep all 2^(2*ceil(log2(LEVELS))) bins at one
// per cycle (65536 bins by default); busy rises once the queue behind it fills.
// The receiver cannot stall: each result is valid for exactly the cycle done is high.
module cooccurrence_matrix_inertia #(
    parameter int LEVELS     = 256,
    parameter int OFFSET_MAX = 8,
    parameter int COUNT_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [cmi_pkg::CFG_BITS-1:0]         cfg_wr_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           kind,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]       pixel,
    input  logic                                 row_start,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]       read_first,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]       read_second,
    output logic                                 done,
    output logic [cmi_pkg::BIN_OUT_BITS-1:0]     bin_count,
    output logic [cmi_pkg::INERTIA_BITS-1:0]     inertia
);

    logic                       accept;
    logic                       q_push;
    cmi_pkg::cmi_req_t          q_push_req;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_empty;
    cmi_pkg::cmi_req_t          q_head;
    cmi_pkg::cmi_back_status_t  back_status;

    assign busy   = q_full;
    assign accept = start && !busy;

    // Front end
    cmi_front #(
        .LEVELS     (LEVELS),
        .OFFSET_MAX (OFFSET_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .kind        (kind),
        .pixel       (pixel),
        .row_start   (row_start),
        .read_first  (read_first),
        .read_second (read_second),
        .push        (q_push),
        .push_req    (q_push_req)
    );

    // Queue between the two ends
    cmi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (q_push_req),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Back end
    cmi_back #(
        .LEVELS     (LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (q_head),
        .pop       (q_pop),
        .done      (done),
        .bin_count (bin_count),
        .inertia   (inertia),
        .status    (back_status)
    );

    // The queue is never written while it is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // No operation is in flight in the second stage while bins are being swept.
    a_sweep_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.sweep_active |-> !back_status.stage2_valid)
        else $error("bin update overlaps the clearing sweep");

    // Once a sweep is under way no result is produced and the inertia sum stays cleared.
    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (back_status.sweep_active && $past(back_status.sweep_active))
            |-> (!done && back_status.inertia_zero))
        else $error("result or inertia change during the clearing sweep");

endmodule

// ----- sim/cooccurrence_matrix_inertia_checker.sv -----
// Scoreboard for the co-occurrence matrix block: tracks requests and checks each read result.
`timescale 1ns / 100ps

module cooccurrence_matrix_inertia_checker #(
    parameter int LEVELS     = 256,
    parameter int OFFSET_MAX = 8,
    parameter int COUNT_BITS = 24
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wr_en,
    input  logic [cmi_pkg::CFG_BITS-1:0]              cfg_wr_data,
    input  logic                                      start,
    input  logic                                      busy,
    input  logic [1:0]                                kind,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]            pixel,
    input  logic                                      row_start,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]            read_first,
    input  logic [cmi_pkg::PIXEL_BITS-1:0]            read_second,
    input  logic                                      done,
    input  logic [cmi_pkg::BIN_OUT_BITS-1:0]          bin_count,
    input  logic [cmi_pkg::INERTIA_BITS-1:0]          inertia,
    output int                                        fail_count,
    output int                                        pending_reads,
    output int                                        results_checked
);

    localparam longint unsigned COUNT_CEIL = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic [cmi_pkg::BIN_OUT_BITS-1:0] bin_count;
        logic [cmi_pkg::INERTIA_BITS-1:0] inertia;
    } bin_reply_t;

    // Replies owed for read requests, oldest first.
    bin_reply_t awaited_reads [$];

    // Predicted state of the block; bins never touched are absent and count as zero.
    longint unsigned                  pair_tally [int unsigned];
    logic [cmi_pkg::INERTIA_BITS-1:0] inertia_sum;
    logic [cmi_pkg::PIXEL_BITS-1:0]   row_hist [OFFSET_MAX];
    int unsigned                      row_pos;
    logic [cmi_pkg::CFG_BITS-1:0]     offset_reg;
    int                               errors  = 0;
    int                               checked = 0;

    // Out-of-range offsets are clamped into 1 .. OFFSET_MAX.
    function automatic int unsigned pair_distance();
        int unsigned d;
        d = 32'(offset_reg);
        if (d < 1)
            d = 1;
        if (d > OFFSET_MAX)
            d = OFFSET_MAX;
        return d;
    endfunction

    // One pixel: pair it with the pixel one offset back, then push it into the history.
    task automatic absorb_pixel(input int unsigned level, input logic first);
        int unsigned                        d;
        int unsigned                        earlier;
        int unsigned                        diff;
        int unsigned                        idx;
        longint unsigned                    sq;
        logic [cmi_pkg::INERTIA_BITS:0]     widened;
        int                                 i;
        d = pair_distance();
        if (level >= LEVELS)
            level = LEVELS - 1;
        if (first)
            row_pos = 0;
        if (row_pos >= d) begin
            earlier = 32'(row_hist[d-1]);
            idx     = earlier * LEVELS + level;
            diff    = (earlier > level) ? earlier - level : level - earlier;
            sq      = 64'(diff * diff);
            if (!pair_tally.exists(idx))
                pair_tally[idx] = 0;
            if (pair_tally[idx] < COUNT_CEIL)
                pair_tally[idx] = pair_tally[idx] + 1;
            widened     = {1'b0, inertia_sum} + (cmi_pkg::INERTIA_BITS+1)'(sq);
            inertia_sum = widened[cmi_pkg::INERTIA_BITS] ? '1
                                                         : widened[cmi_pkg::INERTIA_BITS-1:0];
        end
        for (i = OFFSET_MAX - 1; i > 0; i--)
            row_hist[i] = row_hist[i-1];
        row_hist[0] = level[cmi_pkg::PIXEL_BITS-1:0];
        if (row_pos < OFFSET_MAX)
            row_pos++;
    endtask

    // Reply to a read: the bin count (zero outside the matrix) and the running inertia.
    function automatic bin_reply_t bin_lookup(input int unsigned first_level,
                                              input int unsigned second_level);
        bin_reply_t      reply;
        longint unsigned cnt;
        int unsigned     idx;
        cnt = 0;
        idx = first_level * LEVELS + second_level;
        if (first_level < LEVELS && second_level < LEVELS && pair_tally.exists(idx))
            cnt = pair_tally[idx];
        reply.bin_count = cnt[cmi_pkg::BIN_OUT_BITS-1:0];
        reply.inertia   = inertia_sum;
        return reply;
    endfunction

    // Results are checked first, then the request taken at the same edge updates the prediction;
    // an offset written at that edge applies from the next request on.
    always @(posedge clk or negedge rst_n) begin
        bin_reply_t wanted;
        if (!rst_n) begin
            pair_tally.delete();
            awaited_reads.delete();
            inertia_sum = '0;
            row_hist    = '{default: '0};
            row_pos     = 0;
            offset_reg  = cmi_pkg::CFG_BITS'(1);
            pending_reads <= 0;
        end
        else begin
            if (done) begin
                if (awaited_reads.size() == 0) begin
                    $error("Result with no read waiting: bin_count %0d, inertia %0d",
                           bin_count, inertia);
                    errors++;
                end
                else begin
                    wanted = awaited_reads.pop_front();
                    checked++;
                    if (bin_count !== wanted.bin_count) begin
                        $error("bin_count mismatch: expected %0d, actual %0d",
                               wanted.bin_count, bin_count);
                        errors++;
                    end
                    if (inertia !== wanted.inertia) begin
                        $error("inertia mismatch: expected %0d, actual %0d",
                               wanted.inertia, inertia);
                        errors++;
                    end
                end
            end

            if (start && !busy) begin
                case (kind)
                    cmi_pkg::KIND_PIXEL: absorb_pixel(32'(pixel), row_start);
                    cmi_pkg::KIND_READ:
                        awaited_reads.insert(awaited_reads.size(),
                                             bin_lookup(32'(read_first), 32'(read_second)));
                    cmi_pkg::KIND_CLEAR: begin
                        pair_tally.delete();
                        inertia_sum = '0;
                    end
                    default: ;
                endcase
            end

            if (cfg_wr_en)
                offset_reg = cfg_wr_data;

            pending_reads <= awaited_reads.size();
        end
        fail_count      <= errors;
        results_checked <= checked;
    end

endmodule

// ----- sim/cooccurrence_matrix_inertia_tb.sv -----
// Testbench top for the co-occurrence matrix block: drives requests and gives the verdict.
`timescale 1ns / 100ps

module cooccurrence_matrix_inertia_tb;

    localparam int         LEVELS           = 256;
    localparam int         OFFSET_MAX       = 8;
    localparam int         COUNT_BITS       = 24;
    localparam logic [1:0] KIND_UNUSED      = 2'd3;
    localparam int         CYCLE_LIMIT      = 2_000_000;
    localparam int         RANDOM_CLEAR_CAP = 4;
    localparam int         PHASE_ITEMS      = 115;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [cmi_pkg::CFG_BITS-1:0]     cfg_wr_data = '0;
    logic                             start       = 1'b0;
    logic [1:0]                       kind        = cmi_pkg::KIND_PIXEL;
    logic [cmi_pkg::PIXEL_BITS-1:0]   pixel       = '0;
    logic                             row_start   = 1'b0;
    logic [cmi_pkg::PIXEL_BITS-1:0]   read_first  = '0;
    logic [cmi_pkg::PIXEL_BITS-1:0]   read_second = '0;
    logic                             busy;
    logic                             done;
    logic [cmi_pkg::BIN_OUT_BITS-1:0] bin_count;
    logic [cmi_pkg::INERTIA_BITS-1:0] inertia;

    int fail_count;
    int pending_reads;
    int results_checked;

    int                             idle_pct    = 0;
    int                             clears_left = RANDOM_CLEAR_CAP;
    int                             n_pixels    = 0;
    int                             n_reads     = 0;
    int                             n_clears    = 0;
    int                             n_unused    = 0;
    int                             cycles      = 0;
    logic [cmi_pkg::PIXEL_BITS-1:0] palette [4];

    // 4 ns clock.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cooccurrence_matrix_inertia #(
        .LEVELS     (LEVELS),
        .OFFSET_MAX (OFFSET_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .pixel       (pixel),
        .row_start   (row_start),
        .read_first  (read_first),
        .read_second (read_second),
        .done        (done),
        .bin_count   (bin_count),
        .inertia     (inertia)
    );

    cooccurrence_matrix_inertia_checker #(
        .LEVELS     (LEVELS),
        .OFFSET_MAX (OFFSET_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .pixel           (pixel),
        .row_start       (row_start),
        .read_first      (read_first),
        .read_second     (read_second),
        .done            (done),
        .bin_count       (bin_count),
        .inertia         (inertia),
        .fail_count      (fail_count),
        .pending_reads   (pending_reads),
        .results_checked (results_checked)
    );

    // Watchdog: clears sweep the whole matrix, so the limit is generous.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d reads outstanding",
                     cycles, pending_reads);
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one request after a random idle gap and hold it until the block takes it.
    // Called at a rising edge; returns at the edge that accepted the request, start still high.
    task automatic put_request(input logic [1:0] k, input logic [7:0] px, input logic rs,
                               input logic [7:0] rf, input logic [7:0] rsd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind        <= k;
        pixel       <= px;
        row_start   <= rs;
        read_first  <= rf;
        read_second <= rsd;
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (k)
            cmi_pkg::KIND_PIXEL: n_pixels++;
            cmi_pkg::KIND_READ:  n_reads++;
            cmi_pkg::KIND_CLEAR: n_clears++;
            default:             n_unused++;
        endcase
    endtask

    // Unused fields of each request carry random values.
    task automatic put_pixel(input logic [7:0] px, input logic rs);
        put_request(cmi_pkg::KIND_PIXEL, px, rs, 8'($urandom_range(255)),
                    8'($urandom_range(255)));
    endtask

    task automatic put_read(input logic [7:0] a, input logic [7:0] b);
        put_request(cmi_pkg::KIND_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), a, b);
    endtask

    task automatic put_clear();
        put_request(cmi_pkg::KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // Wait for every read to come back; a read closes each phase so any clear sweep is over.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_reads != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_offset(input logic [cmi_pkg::CFG_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly whole rows drawn from a small palette or the full range, with reads between them;
    // some rows continue without a row start, some carry a stray one, and a few requests are
    // unused kinds or clears.
    task automatic run_phase(input int count);
        int   sent;
        int   r;
        int   len;
        int   j;
        logic narrow;
        logic opened;
        sent       = 0;
        palette[2] = 8'($urandom_range(255));
        palette[3] = 8'($urandom_range(255));
        while (sent < count) begin
            r = $urandom_range(99);
            if (r < 3) begin
                put_request(KIND_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else if (r < 4 && clears_left > 0) begin
                clears_left--;
                put_clear();
                sent++;
            end
            else if (r < 24) begin
                if ($urandom_range(2) != 0)
                    put_read(palette[2'($urandom_range(3))], palette[2'($urandom_range(3))]);
                else
                    put_read(8'($urandom_range(255)), 8'($urandom_range(255)));
                sent++;
            end
            else begin
                len    = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
                narrow = 1'($urandom_range(1));
                opened = ($urandom_range(9) != 0);
                for (j = 0; j < len; j++) begin
                    put_pixel(narrow ? palette[2'($urandom_range(3))] : 8'($urandom_range(255)),
                              (j == 0 && opened) || ($urandom_range(39) == 0));
                    sent++;
                end
            end
        end
        put_read(palette[2'($urandom_range(3))], palette[2'($urandom_range(3))]);
        settle();
    endtask

    initial begin
        palette[0] = 8'd0;
        palette[1] = 8'd255;
        palette[2] = 8'd17;
        palette[3] = 8'd90;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset offset of one: empty matrix, extreme levels,
        // a new row, an unused kind, and a clear that keeps the row history.
        put_read(8'd0, 8'd0);
        put_read(8'd255, 8'd255);
        put_pixel(8'd0, 1'b1);
        put_pixel(8'd255, 1'b0);
        put_pixel(8'd0, 1'b0);
        put_pixel(8'd255, 1'b0);
        put_read(8'd0, 8'd255);
        put_read(8'd255, 8'd0);
        put_request(KIND_UNUSED, 8'd255, 1'b1, 8'd0, 8'd255);
        put_pixel(8'd255, 1'b1);
        put_pixel(8'd255, 1'b0);
        put_read(8'd255, 8'd255);
        put_clear();
        put_read(8'd0, 8'd255);
        put_pixel(8'd7, 1'b0);
        put_read(8'd255, 8'd7);
        settle();

        // Random phases at a range of offsets and idle rates.
        run_phase(PHASE_ITEMS - 15);

        idle_pct = 77;
        write_offset(4'd8);
        run_phase(PHASE_ITEMS);

        idle_pct = 0;
        write_offset(4'd0);
        run_phase(PHASE_ITEMS);

        idle_pct = 33;
        write_offset(4'd15);
        run_phase(PHASE_ITEMS);

        write_offset(4'd9);
        run_phase(PHASE_ITEMS);

        idle_pct = 77;
        write_offset(cmi_pkg::CFG_BITS'($urandom_range(7, 2)));
        run_phase(PHASE_ITEMS);

        $display("Sent %0d pixels, %0d bin reads, %0d clears and %0d unused-kind requests",
                 n_pixels, n_reads, n_clears, n_unused);
        $display("Offsets 1, 8, 0, 15, 9 and one in between; %0d read results compared",
                 results_checked);
        if (fail_count == 0 && pending_reads == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- cooccurrence_matrix_inertia.f -----
rtl/core/cmi_pkg.sv
rtl/core/cmi_ram.sv
rtl/core/cmi_front.sv
rtl/core/cmi_queue.sv
rtl/core/cmi_back.sv
rtl/core/cooccurrence_matrix_inertia.sv
sim/cooccurrence_matrix_inertia_checker.sv
sim/cooccurrence_matrix_inertia_tb.sv
